// File: rtl/core/smx_pkg.sv
// Shared constants, types and helpers for the strided 3-D elementwise max unit.
package smx_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int INDEX_WIDTH = 32;
  localparam int CFG_W       = 60;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int POS_W       = COORD_WIDTH + 1;
  localparam int OPND_W      = COORD_WIDTH + 2;
  localparam int PROD_W      = OPND_W + COORD_WIDTH;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_A_STRIDES   = 3'd0,
    REG_B_STRIDES   = 3'd1,
    REG_A_OFFSETS   = 3'd2,
    REG_B_OFFSETS   = 3'd3,
    REG_OUT_EXTENT  = 3'd4,
    REG_OUT_STRIDES = 3'd5,
    REG_WALK_START  = 3'd6,
    REG_WALK_END    = 3'd7
  } reg_idx_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_bank_t;
  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [POS_W-1:0]        pos_t;

  // Walk stage output, consumed by the index stages.
  typedef struct packed {
    logic        out_valid;
    logic        fetch_valid;
    logic        done;
    pos_t [2:0]  cur;
    pos_t [2:0]  nxt;
    logic [63:0] max_value;
  } walk_res_t;

  // Signed field of one packed register.
  function automatic coord_t fld(input logic [CFG_W-1:0] r, input int unsigned d);
    return r[d*COORD_WIDTH +: COORD_WIDTH];
  endfunction

  // A > B under IEEE double ordering; NaN or equal gives false.
  function automatic logic dbl_gt(input logic [63:0] a, input logic [63:0] b);
    logic a_nan, b_nan, zeros, gt;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
    zeros = (a[62:0] == '0) && (b[62:0] == '0);
    if (a[63] != b[63]) begin
      gt = !a[63];
    end else if (!a[63]) begin
      gt = a[62:0] > b[62:0];
    end else begin
      gt = a[62:0] < b[62:0];
    end
    return gt && !a_nan && !b_nan && !zeros;
  endfunction

endpackage

// File: rtl/core/smx_walk.sv
// Position walker: start/advance logic and max select, registered per request.
module smx_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          req_valid,
  input  logic                          cmd,
  input  logic [63:0]                   a_value,
  input  logic [63:0]                   b_value,
  input  smx_pkg::cfg_bank_t            cfg,
  output smx_pkg::walk_res_t            res,
  output logic                          res_valid
);
  import smx_pkg::*;

  pos_t      pos [3];
  pos_t      pos_next [3];
  logic      walking, walking_next;
  pos_t      sd [3];
  pos_t      ed [3];
  logic      empty [3];
  logic      any_empty;
  walk_res_t res_next;
  logic signed [POS_W:0] inc [3];

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      sd[d]    = POS_W'(fld(cfg[REG_WALK_START], d));
      ed[d]    = POS_W'(fld(cfg[REG_OUT_EXTENT], d)) + POS_W'(fld(cfg[REG_WALK_END], d));
      empty[d] = sd[d] >= ed[d];
      inc[d]   = (POS_W+1)'(pos[d]) + (POS_W+1)'(1);
    end
    any_empty = empty[0] || empty[1] || empty[2];

    res_next = '0;
    walking_next = walking;
    for (int d = 0; d < 3; d++) begin
      pos_next[d] = pos[d];
      res_next.cur[d] = pos[d];
    end

    if (cmd == CMD_START) begin
      for (int d = 0; d < 3; d++) pos_next[d] = sd[d];
      walking_next         = !any_empty;
      res_next.done        = any_empty;
      res_next.fetch_valid = !any_empty;
    end else if (!walking) begin
      res_next.done = 1'b1;
    end else begin
      res_next.out_valid = 1'b1;
      res_next.max_value = dbl_gt(a_value, b_value) ? a_value : b_value;
      // advance k fastest, then j, then i
      if (inc[2] < (POS_W+1)'(ed[2])) begin
        pos_next[2] = pos[2] + POS_W'(1);
        res_next.fetch_valid = 1'b1;
      end else if (inc[1] < (POS_W+1)'(ed[1]) && !empty[2]) begin
        pos_next[1] = pos[1] + POS_W'(1);
        pos_next[2] = sd[2];
        res_next.fetch_valid = 1'b1;
      end else if (inc[0] < (POS_W+1)'(ed[0]) && !empty[1] && !empty[2]) begin
        pos_next[0] = pos[0] + POS_W'(1);
        pos_next[1] = sd[1];
        pos_next[2] = sd[2];
        res_next.fetch_valid = 1'b1;
      end else begin
        walking_next  = 1'b0;
        res_next.done = 1'b1;
      end
    end
    for (int d = 0; d < 3; d++) res_next.nxt[d] = pos_next[d];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking   <= 1'b0;
      res_valid <= 1'b0;
      for (int d = 0; d < 3; d++) pos[d] <= '0;
    end else if (en) begin
      res_valid <= req_valid;
      if (req_valid) begin
        walking <= walking_next;
        for (int d = 0; d < 3; d++) pos[d] <= pos_next[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

endmodule

// File: rtl/core/smx_index.sv
// Index stages: per-dimension products, then sums into the result register.
module smx_index (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    walk_valid,
  input  smx_pkg::walk_res_t      walk,
  input  smx_pkg::cfg_bank_t      cfg,
  output logic                    res_valid,
  output logic                    out_valid,
  output logic signed [31:0]      out_index,
  output logic [63:0]             max_value,
  output logic                    fetch_valid,
  output logic signed [31:0]      a_index,
  output logic signed [31:0]      b_index,
  output logic                    done_res
);
  import smx_pkg::*;

  logic [INDEX_WIDTH-1:0] pa [3];
  logic [INDEX_WIDTH-1:0] pb [3];
  logic [INDEX_WIDTH-1:0] po [3];
  logic [INDEX_WIDTH-1:0] pa_next [3];
  logic [INDEX_WIDTH-1:0] pb_next [3];
  logic [INDEX_WIDTH-1:0] po_next [3];
  logic                   p_valid;
  walk_res_t              p_walk;
  logic [INDEX_WIDTH-1:0] sa, sb, so;

  always_comb begin
    logic signed [OPND_W-1:0] ca, cb;
    logic signed [PROD_W-1:0] ma, mb, mo;
    for (int d = 0; d < 3; d++) begin
      ca = OPND_W'(walk.nxt[d]) + OPND_W'(fld(cfg[REG_A_OFFSETS], d));
      cb = OPND_W'(walk.nxt[d]) + OPND_W'(fld(cfg[REG_B_OFFSETS], d));
      ma = PROD_W'(ca) * PROD_W'(fld(cfg[REG_A_STRIDES], d));
      mb = PROD_W'(cb) * PROD_W'(fld(cfg[REG_B_STRIDES], d));
      mo = PROD_W'(walk.cur[d]) * PROD_W'(fld(cfg[REG_OUT_STRIDES], d));
      pa_next[d] = ma[INDEX_WIDTH-1:0];
      pb_next[d] = mb[INDEX_WIDTH-1:0];
      po_next[d] = mo[INDEX_WIDTH-1:0];
    end
  end

  assign sa = pa[0] + pa[1] + pa[2];
  assign sb = pb[0] + pb[1] + pb[2];
  assign so = po[0] + po[1] + po[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= walk_valid;
      res_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_walk <= walk;
      for (int d = 0; d < 3; d++) begin
        pa[d] <= pa_next[d];
        pb[d] <= pb_next[d];
        po[d] <= po_next[d];
      end
      out_valid   <= p_walk.out_valid;
      fetch_valid <= p_walk.fetch_valid;
      done_res    <= p_walk.done;
      max_value   <= p_walk.out_valid ? p_walk.max_value : '0;
      out_index   <= p_walk.out_valid ? 32'(signed'(so)) : '0;
      a_index     <= p_walk.fetch_valid ? 32'(signed'(sa)) : '0;
      b_index     <= p_walk.fetch_valid ? 32'(signed'(sb)) : '0;
    end
  end

endmodule

// File: rtl/core/strided_3d_elementwise_max_unit.sv
// Top level of the strided 3-D elementwise max unit.
//
//   channel   direction  handshake             payload
//   in        request in in_valid / in_ready   cmd, a_value, b_value
//   res       result out res_valid / res_ready out_valid, out_index, max_value,
//                                              fetch_valid, a_index, b_index, done_res
//   cfg       write in   cfg_we                cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; each request yields
// exactly one result (input reg, walk reg, product reg, result reg).
// The walk position and walking flag are the only loop-carried state, held in the walk stage.
// All stages hold together while a result waits on res_ready; in_ready drops
// only then. Synchronous reset clears config, position and stage valids.
module strided_3d_elementwise_max_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [63:0]                     a_value,
  input  logic [63:0]                     b_value,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            out_valid,
  output logic signed [31:0]              out_index,
  output logic [63:0]                     max_value,
  output logic                            fetch_valid,
  output logic signed [31:0]              a_index,
  output logic signed [31:0]              b_index,
  output logic                            done_res,
  input  logic                            cfg_we,
  input  logic [smx_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [smx_pkg::CFG_W-1:0]       cfg_data
);
  import smx_pkg::*;

  cfg_bank_t   cfg;
  logic        en;
  logic        s0_valid;
  logic        s0_cmd;
  logic [63:0] s0_a, s0_b;
  walk_res_t   walk;
  logic        walk_valid;

  // advance every stage unless a finished result is stuck at the output
  assign en       = !res_valid || res_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cmd <= cmd;
      s0_a   <= a_value;
      s0_b   <= b_value;
    end
  end

  smx_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (s0_valid),
    .cmd       (s0_cmd),
    .a_value   (s0_a),
    .b_value   (s0_b),
    .cfg       (cfg),
    .res       (walk),
    .res_valid (walk_valid)
  );

  smx_index u_index (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .walk_valid  (walk_valid),
    .walk        (walk),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .out_valid   (out_valid),
    .out_index   (out_index),
    .max_value   (max_value),
    .fetch_valid (fetch_valid),
    .a_index     (a_index),
    .b_index     (b_index),
    .done_res    (done_res)
  );

endmodule

// File: rtl/core/smx_checker.sv
// Port-level checks for the strided 3-D elementwise max unit, bound to the top.
module smx_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic               out_valid,
  input logic signed [31:0] out_index,
  input logic [63:0]        max_value,
  input logic               fetch_valid,
  input logic signed [31:0] a_index,
  input logic               done_res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(max_value) && $stable(a_index))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(fetch_valid && done_res))
    else $error("fetch and done together");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_index == 0 && max_value == 0)
    else $error("result fields not cleared");

  a_rdy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !in_ready)
    else $error("request taken while output stalled");

endmodule

bind strided_3d_elementwise_max_unit smx_checker u_smx_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .out_valid   (out_valid),
  .out_index   (out_index),
  .max_value   (max_value),
  .fetch_valid (fetch_valid),
  .a_index     (a_index),
  .done_res    (done_res)
);
